/* rtl/newton_interpolation_engine_assert.svh */
// ----------------------------------------------------------------------------
// Newton interpolation engine assertion macros
// Shared implication checks used by the RTL.
// ----------------------------------------------------------------------------
`ifndef NEWTON_INTERPOLATION_ENGINE_ASSERT_SVH
`define NEWTON_INTERPOLATION_ENGINE_ASSERT_SVH

// same-cycle implication
`define NIE_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// next-cycle implication
`define NIE_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

/* rtl/nie_pkg.sv */
// ----------------------------------------------------------------------------
// nie_pkg
// Types, constants and saturating helpers for the Newton interpolation engine.
// ----------------------------------------------------------------------------
`default_nettype none
package nie_pkg;

    localparam int MAX_POINTS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int COEF_FRAC  = 32;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REPEAT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_SAT    = 2'd3;

    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic               restart;
        logic signed [31:0] x_value;
        logic signed [31:0] y_value;
    } t_req;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [1:0]         status;
        logic [4:0]         points_held;
    } t_rsp;

    function automatic logic [63:0] magnitude(input logic [63:0] v);
        magnitude = v[63] ? (64'd0 - v) : v;
    endfunction

    // returns {sat, value}
    function automatic logic [64:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] d;
        d = {a[63], a} - {b[63], b};
        if (d[64] != d[63]) begin
            sat_sub = {1'b1, d[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF};
        end else begin
            sat_sub = {1'b0, d[63:0]};
        end
    endfunction

    // sign plus 128-bit magnitude to saturated signed 64, returns {sat, value}
    function automatic logic [64:0] to_signed(input logic neg, input logic [127:0] mag);
        logic [63:0] limit;
        logic [63:0] lo;
        logic        sat;
        limit = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        lo    = mag[63:0];
        sat   = 1'b0;
        if ((mag[127:64] != 64'd0) || (mag[63:0] > limit)) begin
            sat = 1'b1;
            lo  = limit;
        end
        to_signed = {sat, neg ? (64'd0 - lo) : lo};
    endfunction

endpackage
`default_nettype wire

/* rtl/newton_interpolation_engine.sv */
// ----------------------------------------------------------------------------
// newton_interpolation_engine
// Newton-form interpolation: add points, evaluate the polynomial.
// ----------------------------------------------------------------------------
// Usage: drive i_req and pulse start while busy is low; the request is taken
// at that edge and busy rises the next cycle, except for a full-store add,
// which is answered without leaving idle. When the work is done, o_valid
// is high for exactly one cycle with o_rsp, and busy is low from that same
// cycle, so a new request may be issued at once. The receiver cannot stall.
// Operation: an add or evaluate walks all n stored points through one shared
// 32x32 multiplier (four partial products per 64-bit product, two products
// per point). Unless the abscissa repeats, an add then runs a bit-serial
// 128-step divider for the coefficient.
// Reset empties the point store (count to zero); no clearing pass is needed
// since entries above the count are never read.
// ----------------------------------------------------------------------------
`default_nettype none
`include "newton_interpolation_engine_assert.svh"
module newton_interpolation_engine
    import nie_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_req i_req,
    output logic      busy,
    output logic      o_valid,
    output t_rsp      o_rsp
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_SETT  = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_MFIN  = 4'd4;
    localparam logic [3:0] S_APPLY = 4'd5;
    localparam logic [3:0] S_ENDL  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_DFIN  = 4'd8;

    localparam logic [63:0] P_ONE = 64'd1 << FRAC_BITS;

    logic [31:0] mem_x [MAX_POINTS];
    logic [63:0] mem_c [MAX_POINTS];

    logic [3:0]       r_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_j;
    logic             r_eval;
    logic             r_sat;
    logic             r_phase;
    logic [31:0]      r_z;
    logic [63:0]      r_s;
    logic [63:0]      r_p;
    logic [31:0]      r_xj;
    logic [63:0]      r_cj;
    logic [63:0]      r_ma;
    logic [63:0]      r_mb;
    logic             r_neg;
    logic [127:0]     r_acc;
    logic [1:0]       r_mstep;
    logic [63:0]      r_mres;
    logic [127:0]     r_dq;
    logic [63:0]      r_rem;
    logic [63:0]      r_md;
    logic [6:0]       r_dcnt;
    logic             r_valid;
    t_rsp             r_rsp;
    logic             r_wr;

    logic [CNT_W-1:0] eff_count;
    logic [31:0]      a_part;
    logic [31:0]      b_part;
    logic [63:0]      pp;
    logic [127:0]     n_acc;
    logic [127:0]     shifted;
    logic [64:0]      mfin_ts;
    logic [64:0]      sub_ts;
    logic [63:0]      diff;
    logic [64:0]      neg_ts;
    logic [64:0]      div_ts;
    logic [63:0]      rem_sh;
    logic             q_bit;

    assign eff_count = (i_req.req_type == REQ_ADD && i_req.restart) ? '0 : r_count;

    // shared multiplier datapath: one 32x32 partial product per cycle
    always_comb begin
        a_part = r_ma[31:0];
        b_part = r_mb[31:0];
        case (r_mstep)
            2'd0: begin a_part = r_ma[31:0];  b_part = r_mb[31:0];  end
            2'd1: begin a_part = r_ma[31:0];  b_part = r_mb[63:32]; end
            2'd2: begin a_part = r_ma[63:32]; b_part = r_mb[31:0];  end
            2'd3: begin a_part = r_ma[63:32]; b_part = r_mb[63:32]; end
            default: begin a_part = r_ma[31:0]; b_part = r_mb[31:0]; end
        endcase
        pp = a_part * b_part;
        case (r_mstep)
            2'd0:    n_acc = r_acc + {64'd0, pp};
            2'd3:    n_acc = r_acc + {pp, 64'd0};
            default: n_acc = r_acc + {32'd0, pp, 32'd0};
        endcase
    end

    always_comb begin
        shifted = r_phase ? (r_acc >> FRAC_BITS) : (r_acc >> COEF_FRAC);
        mfin_ts = to_signed(r_neg, shifted);
        sub_ts  = sat_sub(r_s, r_mres);
        diff    = {{32{r_z[31]}}, r_z} - {{32{r_xj[31]}}, r_xj};
        neg_ts  = sat_sub(64'd0, r_s);
        div_ts  = to_signed(r_neg, r_dq);
        rem_sh  = {r_rem[62:0], r_dq[127]};
        q_bit   = r_rem[63] || (rem_sh >= r_md);
    end

    // point store
    always_ff @(posedge i_clk) begin
        if (r_wr) begin
            mem_x[r_count[IDX_W-1:0]] <= r_z;
            mem_c[r_count[IDX_W-1:0]] <= div_ts[63:0];
        end
        r_xj <= mem_x[r_j[IDX_W-1:0]];
        r_cj <= mem_c[r_j[IDX_W-1:0]];
    end

    assign r_wr = (r_state == S_DFIN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_count <= eff_count;
                        r_eval  <= i_req.req_type;
                        r_z     <= i_req.x_value;
                        r_s     <= (i_req.req_type == REQ_ADD) ?
                                   {{32{i_req.y_value[31]}}, i_req.y_value} : 64'd0;
                        r_p     <= P_ONE;
                        r_j     <= '0;
                        r_sat   <= 1'b0;
                        if (i_req.req_type == REQ_ADD && eff_count >= CNT_W'(MAX_POINTS)) begin
                            r_valid             <= 1'b1;
                            r_rsp.result_value  <= '0;
                            r_rsp.status        <= ST_FULL;
                            r_rsp.points_held   <= 5'(eff_count);
                        end else if (eff_count == '0) begin
                            r_state <= S_ENDL;
                        end else begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_LOAD: r_state <= S_SETT;
                S_SETT: begin
                    r_ma    <= magnitude(r_cj);
                    r_mb    <= magnitude(r_p);
                    r_neg   <= r_cj[63] ^ r_p[63];
                    r_acc   <= '0;
                    r_mstep <= '0;
                    r_phase <= 1'b0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_acc   <= n_acc;
                    r_mstep <= r_mstep + 2'd1;
                    if (r_mstep == 2'd3) begin
                        r_state <= S_MFIN;
                    end
                end
                S_MFIN: begin
                    r_mres  <= mfin_ts[63:0];
                    r_sat   <= r_sat | mfin_ts[64];
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    if (!r_phase) begin
                        r_s     <= sub_ts[63:0];
                        r_sat   <= r_sat | sub_ts[64];
                        r_ma    <= magnitude(r_p);
                        r_mb    <= magnitude(diff);
                        r_neg   <= r_p[63] ^ diff[63];
                        r_acc   <= '0;
                        r_mstep <= '0;
                        r_phase <= 1'b1;
                        r_state <= S_MUL;
                    end else begin
                        r_p <= r_mres;
                        r_j <= r_j + CNT_W'(1);
                        r_state <= ((r_j + CNT_W'(1)) < r_count) ? S_LOAD : S_ENDL;
                    end
                end
                S_ENDL: begin
                    if (r_eval == REQ_EVAL) begin
                        r_valid            <= 1'b1;
                        r_state            <= S_IDLE;
                        r_rsp.points_held  <= 5'(r_count);
                        // clamp the negated sum to Q16.16
                        if (neg_ts[63:31] != {33{neg_ts[63]}}) begin
                            r_rsp.result_value <= neg_ts[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                            r_rsp.status       <= ST_SAT;
                        end else begin
                            r_rsp.result_value <= neg_ts[31:0];
                            r_rsp.status       <= (r_sat | neg_ts[64]) ? ST_SAT : ST_OK;
                        end
                    end else if (r_p == 64'd0) begin
                        r_valid            <= 1'b1;
                        r_state            <= S_IDLE;
                        r_rsp.result_value <= '0;
                        r_rsp.status       <= ST_REPEAT;
                        r_rsp.points_held  <= 5'(r_count);
                    end else begin
                        r_dq    <= {32'd0, magnitude(r_s), 32'd0};
                        r_md    <= magnitude(r_p);
                        r_rem   <= '0;
                        r_neg   <= r_s[63] ^ r_p[63];
                        r_dcnt  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= q_bit ? (rem_sh - r_md) : rem_sh;
                    r_dq   <= {r_dq[126:0], q_bit};
                    r_dcnt <= r_dcnt + 7'd1;
                    if (r_dcnt == 7'd127) begin
                        r_state <= S_DFIN;
                    end
                end
                S_DFIN: begin
                    r_count            <= r_count + CNT_W'(1);
                    r_valid            <= 1'b1;
                    r_state            <= S_IDLE;
                    r_rsp.result_value <= '0;
                    r_rsp.status       <= (r_sat | div_ts[64]) ? ST_SAT : ST_OK;
                    r_rsp.points_held  <= 5'(r_count + CNT_W'(1));
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    `NIE_ASSERT_IMP(a_valid_not_busy, i_clk, i_rst_n, o_valid, !busy)
    `NIE_ASSERT_NXT(a_take_busy, i_clk, i_rst_n,
        start && !busy && (i_req.req_type == REQ_EVAL), busy)
    `NIE_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_POINTS))
    `NIE_ASSERT_IMP(a_full_count, i_clk, i_rst_n,
        o_valid && (o_rsp.status == ST_FULL), o_rsp.points_held == 5'(MAX_POINTS))

endmodule
`default_nettype wire

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// Newton interpolation engine testbench
// Drives add-point and evaluate requests with random gaps, predicts each
// response with a fixed-point model of the Newton-form polynomial and checks
// every response field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

class interp_scoreboard;
    logic signed [63:0] xs [nie_pkg::MAX_POINTS];
    logic signed [63:0] cs [nie_pkg::MAX_POINTS];
    int unsigned        npts;
    nie_pkg::t_rsp      pending[$];
    int                 errors;

    function new();
        npts   = 0;
        errors = 0;
    endfunction

    static function logic [63:0] mag64(logic signed [63:0] v);
        return v < 0 ? 64'd0 - v : v;
    endfunction

    static function logic signed [63:0] clamp(logic neg, logic [127:0] m, ref logic sat);
        logic [63:0] lim;
        lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        if (m > {64'd0, lim}) begin
            sat = 1'b1;
            m   = {64'd0, lim};
        end
        return neg ? 64'd0 - m[63:0] : m[63:0];
    endfunction

    static function logic signed [63:0] mulsh(logic signed [63:0] a, logic signed [63:0] b,
                                              int sh, ref logic sat);
        logic [127:0] p;
        p = {64'd0, mag64(a)} * {64'd0, mag64(b)};
        return clamp((a < 0) != (b < 0), p >> sh, sat);
    endfunction

    static function logic signed [63:0] ssub(logic signed [63:0] a, logic signed [63:0] b,
                                             ref logic sat);
        logic signed [64:0] d;
        d = 65'(a) - 65'(b);
        if (d > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
            sat = 1'b1;
            return 64'h7FFF_FFFF_FFFF_FFFF;
        end
        if (d < -65'sh0_8000_0000_0000_0000) begin
            sat = 1'b1;
            return 64'h8000_0000_0000_0000;
        end
        return d[63:0];
    endfunction

    // residual y - sum of earlier terms; prod gets the difference product
    function logic signed [63:0] newton_residual(logic signed [63:0] z, logic signed [63:0] s0,
                                                 output logic signed [63:0] prod,
                                                 ref logic sat);
        logic signed [63:0] p, s, term;
        p = 64'sd1 <<< nie_pkg::FRAC_BITS;
        s = s0;
        for (int j = 0; j < npts; j++) begin
            term = mulsh(cs[j], p, nie_pkg::COEF_FRAC, sat);
            s    = ssub(s, term, sat);
            p    = mulsh(p, z - xs[j], nie_pkg::FRAC_BITS, sat);
        end
        prod = p;
        return s;
    endfunction

    function void note_request(nie_pkg::t_req r);
        nie_pkg::t_rsp      e;
        logic               sat;
        logic signed [63:0] z, s, prod, v;
        logic [127:0]       q;
        sat = 1'b0;
        z   = 64'(r.x_value);
        e   = '0;
        if (r.req_type == nie_pkg::REQ_ADD) begin
            if (r.restart) npts = 0;
            if (npts >= nie_pkg::MAX_POINTS) begin
                e.status = nie_pkg::ST_FULL;
            end else begin
                s = newton_residual(z, 64'(r.y_value), prod, sat);
                if (prod == 0) begin
                    e.status = nie_pkg::ST_REPEAT;
                end else begin
                    q = ({64'd0, mag64(s)} << nie_pkg::COEF_FRAC) / {64'd0, mag64(prod)};
                    cs[npts] = clamp((s < 0) != (prod < 0), q, sat);
                    xs[npts] = z;
                    npts++;
                    e.status = sat ? nie_pkg::ST_SAT : nie_pkg::ST_OK;
                end
            end
        end else begin
            s = newton_residual(z, 64'sd0, prod, sat);
            v = ssub(64'sd0, s, sat);
            if (v > 64'sd2147483647) begin
                v   = 64'sd2147483647;
                sat = 1'b1;
            end
            if (v < -64'sd2147483648) begin
                v   = -64'sd2147483648;
                sat = 1'b1;
            end
            e.result_value = v[31:0];
            e.status       = sat ? nie_pkg::ST_SAT : nie_pkg::ST_OK;
        end
        e.points_held = npts[4:0];
        pending = {pending, e};
    endfunction

    function void report(string what, logic [31:0] want, nie_pkg::t_rsp got);
        $display("mismatch %s: want %h, got value %h status %0d held %0d", what, want,
                 got.result_value, got.status, got.points_held);
        errors++;
    endfunction

    function void check_response(nie_pkg::t_rsp got);
        nie_pkg::t_rsp e;
        if (pending.size() == 0) begin
            report("unexpected response", 0, got);
            return;
        end
        e = pending.pop_front();
        if (got.result_value !== e.result_value) report("result_value", e.result_value, got);
        if (got.status !== e.status)             report("status", e.status, got);
        if (got.points_held !== e.points_held)   report("points_held", e.points_held, got);
    endfunction
endclass

module tb_top;
    import nie_pkg::*;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start = 1'b0;
    t_req          i_req = '0;
    logic          busy;
    logic          o_valid;
    t_rsp          o_rsp;
    longint        cycles = 0;
    interp_scoreboard sb = new();

    localparam longint CYCLE_LIMIT = 4_000_000;

    newton_interpolation_engine u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_req  (i_req),
        .busy   (busy),
        .o_valid(o_valid),
        .o_rsp  (o_rsp)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_valid) sb.check_response(o_rsp);
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 300) : $urandom_range(0, 3);
        repeat (n) @(negedge i_clk);
    endtask

    task automatic issue(logic kind, logic rst, logic [31:0] x, logic [31:0] y);
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        i_req.req_type <= kind;
        i_req.restart  <= rst;
        i_req.x_value  <= x;
        i_req.y_value  <= y;
        start          <= 1'b1;
        @(posedge i_clk);
        sb.note_request('{kind, rst, x, y});
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 16)) - 8) <<< 16;
            2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            default: return 32'($signed($urandom_range(0, 2047)) - 1024) <<< 12;
        endcase
    endfunction

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        logic [31:0] x;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty evaluate, extremes, repeated abscissa, full store
        issue(REQ_EVAL, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
        issue(REQ_ADD, 1'b0, 32'h0000_0000, 32'h7FFF_FFFF);
        issue(REQ_ADD, 1'b0, 32'h0000_0000, 32'h0001_0000);
        issue(REQ_ADD, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000);
        issue(REQ_EVAL, 1'b0, 32'h8000_0000, 32'h0);
        issue(REQ_EVAL, 1'b0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        issue(REQ_ADD, 1'b0, 32'h0000_0001, 32'h0);
        issue(REQ_ADD, 1'b1, 32'hFFFF_0000, 32'h0002_0000);
        for (int i = 0; i < 17; i++)
            issue(REQ_ADD, 1'b0, 32'(i) <<< 16, 32'(i * i) <<< 14);
        issue(REQ_EVAL, 1'b0, 32'h0002_8000, 32'h0);

        drain();
        repeat (400) @(negedge i_clk);
        for (int i = 0; i < 1075; i++) begin
            if ($urandom_range(0, 29) == 0) begin
                issue(REQ_ADD, 1'b1, pick_value(), pick_value());
                for (int k = $urandom_range(0, 17); k > 0; k--) begin
                    x = ($urandom_range(0, 3) == 0) ? pick_value()
                        : 32'($signed($urandom_range(0, 64)) - 32) <<< $urandom_range(12, 16);
                    issue(REQ_ADD, 1'b0, x, pick_value());
                    i++;
                end
            end else begin
                issue($urandom_range(0, 2) != 0, $urandom_range(0, 20) == 0,
                      pick_value(), pick_value());
            end
            if (i == 500) drain();
            if ($urandom_range(0, 1)) idle_gap();
        end

        drain();
        repeat (400) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
